### rtl/mdpc_pkg.sv
// ----------------------------------------------------------------------------
// mdpc_pkg
// Shared constants and helpers for the marker docking phase controller:
// phase codes, command codes, register indexes and velocity step values.
// ----------------------------------------------------------------------------
package mdpc_pkg;

    // phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_WAIT   = 3'd1;
    localparam logic [2:0] PH_CENTER = 3'd2;
    localparam logic [2:0] PH_RANGE  = 3'd3;
    localparam logic [2:0] PH_ROTATE = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // register indexes
    localparam logic [2:0] CFG_CENTER_TOL = 3'd0;
    localparam logic [2:0] CFG_NEAR_LIMIT = 3'd1;
    localparam logic [2:0] CFG_FAR_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_PITCH_TOL  = 3'd3;
    localparam logic [2:0] CFG_APPR_STOP  = 3'd4;
    localparam logic [2:0] CFG_VIEW_OUTER = 3'd5;
    localparam logic [2:0] CFG_VIEW_INNER = 3'd6;

    // register reset values
    localparam logic [11:0] RST_CENTER_TOL = 12'd100;
    localparam logic [13:0] RST_NEAR_LIMIT = 14'd1500;
    localparam logic [13:0] RST_FAR_LIMIT  = 14'd2000;
    localparam logic [11:0] RST_PITCH_TOL  = 12'd500;
    localparam logic [13:0] RST_APPR_STOP  = 14'd1000;
    localparam logic [23:0] RST_VIEW_OUTER = 24'd500000;
    localparam logic [23:0] RST_VIEW_INNER = 24'd400000;

    // velocity steps
    localparam logic signed [7:0] STEP_LIN    = 8'sd100;
    localparam logic signed [8:0] STEP_TURN   = 9'sd100;
    localparam logic signed [8:0] SEARCH_TURN = -9'sd200;

    // hysteresis term taken off the inner limit while approaching
    localparam logic signed [25:0] HYST_AREA = 26'sd600000;

    // +step when pos, -step when neg, zero otherwise
    function automatic logic signed [8:0] step_turn(input logic pos, input logic neg);
        logic signed [8:0] r;
        r = 9'sd0;
        if (pos)
        begin
            r = STEP_TURN;
        end
        else if (neg)
        begin
            r = -STEP_TURN;
        end
        return r;
    endfunction

endpackage

### rtl/marker_docking_phase_controller.sv
// ----------------------------------------------------------------------------
// marker_docking_phase_controller
// Bang-bang docking sequencer: centering, ranging and rotating phases driven
// by marker pose ticks, with one shared 32x32 multiplier for the view tests.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    command, pos_x_mm, pos_z_mm, pitch_mrad
//  out       out_valid / out_ready  linear_speed, turn_rate, phase_now, last,
//                                   finished
//  cfg       cfg_we                 cfg_index, cfg_data
//
//  a start request has its result valid right after the accepting edge
//  a tick runs the shared multiplier through x^2, z^2, outer^2, inner^2 and
//  x^2*d^2, then an evaluate state registers the first result;
//  each further result comes from another evaluate state after the previous one is taken
//  in_ready is high only while idle with no result pending
//  a tick in idle or done phase gives no result and returns at once
//  rst_n clears phase, hysteresis flag, aligned pitch and loads register defaults
// ----------------------------------------------------------------------------
module marker_docking_phase_controller
    import mdpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic signed [15:0] pos_x_mm,
    input  logic signed [15:0] pos_z_mm,
    input  logic signed [12:0] pitch_mrad,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [7:0] linear_speed,
    output logic signed [8:0] turn_rate,
    output logic [2:0]        phase_now,
    output logic              last,
    output logic              finished,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [23:0]       cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_OUT
    } state_t;

    localparam logic [2:0] MSTEP_LAST = 3'd4;

    state_t state_reg;
    logic [2:0] mstep_reg;

    // configuration
    logic [11:0] center_tol_reg;
    logic [13:0] near_limit_reg;
    logic [13:0] far_limit_reg;
    logic [11:0] pitch_tol_reg;
    logic [13:0] appr_stop_reg;
    logic [23:0] view_outer_reg;
    logic [23:0] view_inner_reg;

    // block state
    logic [2:0]         phase_reg;
    logic signed [12:0] aligned_reg;
    logic               appr_flag_reg;

    // latched request and products
    logic signed [15:0] x_reg;
    logic signed [15:0] z_reg;
    logic signed [12:0] p_reg;
    logic [30:0] x2_reg;
    logic [30:0] z2_reg;
    logic [31:0] d2_reg;
    logic [47:0] co2_reg;
    logic [47:0] ci2_reg;
    logic [61:0] xd_reg;

    // output registers
    logic              out_valid_reg;
    logic signed [7:0] lin_reg;
    logic signed [8:0] turn_reg;
    logic [2:0]        phase_out_reg;
    logic              last_reg;

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    logic [15:0] abs_x;
    logic [15:0] abs_z;
    logic [12:0] abs_aligned;
    logic signed [25:0] inner_c;
    logic [23:0] inner_mag;

    // one evaluation step
    logic signed [7:0] ev_lin;
    logic signed [8:0] ev_turn;
    logic [2:0]        ev_phase;
    logic              ev_last;
    logic              ev_angle_we;
    logic              ev_flag_we;
    logic              ev_flag;
    logic              outer_ok;
    logic              inner_ok;

    assign abs_x       = x_reg[15] ? (~x_reg + 16'd1) : x_reg;
    assign abs_z       = z_reg[15] ? (~z_reg + 16'd1) : z_reg;
    assign abs_aligned = aligned_reg[12] ? (~aligned_reg + 13'd1) : aligned_reg;
    assign inner_c     = $signed({2'b00, view_inner_reg}) - (appr_flag_reg ? HYST_AREA : 26'sd0);
    assign inner_mag   = inner_c[23:0];

    always_comb
    begin
        case (mstep_reg)
            3'd0:
            begin
                mul_a = {16'd0, abs_x};
                mul_b = {16'd0, abs_x};
            end
            3'd1:
            begin
                mul_a = {16'd0, abs_z};
                mul_b = {16'd0, abs_z};
            end
            3'd2:
            begin
                mul_a = {8'd0, view_outer_reg};
                mul_b = {8'd0, view_outer_reg};
            end
            3'd3:
            begin
                mul_a = {8'd0, inner_mag};
                mul_b = {8'd0, inner_mag};
            end
            3'd4:
            begin
                mul_a = {1'b0, x2_reg};
                mul_b = d2_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign outer_ok = (xd_reg <= {14'd0, co2_reg});
    assign inner_ok = !inner_c[25] && (xd_reg <= {14'd0, ci2_reg});

    always_comb
    begin
        ev_lin      = 8'sd0;
        ev_turn     = 9'sd0;
        ev_phase    = phase_reg;
        ev_last     = 1'b1;
        ev_angle_we = 1'b0;
        ev_flag_we  = 1'b0;
        ev_flag     = 1'b0;
        case (phase_reg)
            PH_CENTER, PH_RANGE:
            begin
                if (phase_reg == PH_CENTER && abs_x >= {4'd0, center_tol_reg})
                begin
                    ev_turn = step_turn(x_reg < 0, x_reg > 0);
                end
                else if (z_reg <= $signed({2'b00, near_limit_reg}))
                begin
                    ev_lin = -STEP_LIN;
                end
                else if (z_reg >= $signed({2'b00, far_limit_reg}))
                begin
                    ev_lin = STEP_LIN;
                end
                else
                begin
                    // phase passed, same tick goes on to the next phase
                    ev_angle_we = (phase_reg == PH_CENTER);
                    ev_phase    = phase_reg + 3'd1;
                    ev_last     = 1'b0;
                end
            end
            PH_ROTATE:
            begin
                if (abs_aligned <= {1'b0, pitch_tol_reg})
                begin
                    ev_phase = PH_DONE;
                end
                else if (outer_ok)
                begin
                    ev_flag_we = 1'b1;
                    if (inner_ok)
                    begin
                        ev_turn = step_turn(p_reg > 0, p_reg < 0);
                    end
                    else if (abs_z >= {2'd0, appr_stop_reg})
                    begin
                        ev_flag = 1'b1;
                        ev_lin  = STEP_LIN;
                    end
                    else
                    begin
                        ev_phase = PH_CENTER;
                    end
                end
                else
                begin
                    ev_turn = step_turn(p_reg < 0, p_reg > 0);
                end
            end
            default:
            begin
                ev_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mstep_reg      <= 3'd0;
            center_tol_reg <= RST_CENTER_TOL;
            near_limit_reg <= RST_NEAR_LIMIT;
            far_limit_reg  <= RST_FAR_LIMIT;
            pitch_tol_reg  <= RST_PITCH_TOL;
            appr_stop_reg  <= RST_APPR_STOP;
            view_outer_reg <= RST_VIEW_OUTER;
            view_inner_reg <= RST_VIEW_INNER;
            phase_reg      <= PH_IDLE;
            aligned_reg    <= 13'sd0;
            appr_flag_reg  <= 1'b0;
            x_reg          <= 16'sd0;
            z_reg          <= 16'sd0;
            p_reg          <= 13'sd0;
            x2_reg         <= 31'd0;
            z2_reg         <= 31'd0;
            d2_reg         <= 32'd0;
            co2_reg        <= 48'd0;
            ci2_reg        <= 48'd0;
            xd_reg         <= 62'd0;
            out_valid_reg  <= 1'b0;
            lin_reg        <= 8'sd0;
            turn_reg       <= 9'sd0;
            phase_out_reg  <= PH_IDLE;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTER_TOL: center_tol_reg <= cfg_data[11:0];
                    CFG_NEAR_LIMIT: near_limit_reg <= cfg_data[13:0];
                    CFG_FAR_LIMIT:  far_limit_reg  <= cfg_data[13:0];
                    CFG_PITCH_TOL:  pitch_tol_reg  <= cfg_data[11:0];
                    CFG_APPR_STOP:  appr_stop_reg  <= cfg_data[13:0];
                    CFG_VIEW_OUTER: view_outer_reg <= cfg_data;
                    CFG_VIEW_INNER: view_inner_reg <= cfg_data;
                    default:        ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (command == CMD_START)
                        begin
                            phase_reg     <= PH_WAIT;
                            lin_reg       <= 8'sd0;
                            turn_reg      <= SEARCH_TURN;
                            phase_out_reg <= PH_WAIT;
                            last_reg      <= 1'b1;
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                        else if (phase_reg inside {[PH_WAIT:PH_ROTATE]})
                        begin
                            x_reg     <= pos_x_mm;
                            z_reg     <= pos_z_mm;
                            p_reg     <= pitch_mrad;
                            mstep_reg <= 3'd0;
                            state_reg <= ST_MUL;
                            if (phase_reg == PH_WAIT)
                            begin
                                phase_reg <= PH_CENTER;
                            end
                        end
                    end
                end
                ST_MUL:
                begin
                    case (mstep_reg)
                        3'd0: x2_reg <= mul_p[30:0];
                        3'd1: z2_reg <= mul_p[30:0];
                        3'd2:
                        begin
                            co2_reg <= mul_p[47:0];
                            d2_reg  <= {1'b0, x2_reg} + {1'b0, z2_reg};
                        end
                        3'd3: ci2_reg <= mul_p[47:0];
                        3'd4: xd_reg  <= mul_p[61:0];
                        default: ;
                    endcase
                    mstep_reg <= mstep_reg + 3'd1;
                    if (mstep_reg == MSTEP_LAST)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    phase_reg     <= ev_phase;
                    lin_reg       <= ev_lin;
                    turn_reg      <= ev_turn;
                    phase_out_reg <= ev_phase;
                    last_reg      <= ev_last;
                    out_valid_reg <= 1'b1;
                    if (ev_angle_we)
                    begin
                        aligned_reg <= p_reg;
                    end
                    if (ev_flag_we)
                    begin
                        appr_flag_reg <= ev_flag;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= last_reg ? ST_IDLE : ST_EVAL;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign linear_speed = lin_reg;
    assign turn_rate    = turn_reg;
    assign phase_now    = phase_out_reg;
    assign last         = last_reg;
    assign finished     = (phase_out_reg == PH_DONE);

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid)
        else $error("request taken while a result is pending");

    // the final result of a request frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> in_ready)
        else $error("block not idle after final result");

    // no result while the multiplier is running
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> !out_valid)
        else $error("result shown during multiply sequence");

    // waiting phase only ever reported by the search turn of a start request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_now == PH_WAIT |-> turn_rate == SEARCH_TURN && last)
        else $error("bad result in waiting phase");

endmodule
